@@ design/light_event_scheduler_unit_macros.svh @@
// Assertion macros shared by the light event scheduler RTL.
`ifndef LIGHT_EVENT_SCHEDULER_UNIT_MACROS_SVH
`define LIGHT_EVENT_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LESU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lesu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LESU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lesu assertion failed");

`endif

@@ design/lesu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesu_pkg
// Types, constants and helpers shared by the light event scheduler.
// ----------------------------------------------------------------------------
package lesu_pkg;

    localparam int LESU_MAX_EVENTS = 32;

    localparam int LIGHT_W  = 8;
    localparam int DAY_W    = 4;
    localparam int MINUTE_W = 11;

    localparam logic ACT_SCHEDULE = 1'b0;
    localparam logic ACT_TICK     = 1'b1;

    localparam logic [DAY_W-1:0] DAY_SUNDAY   = 4'd0;
    localparam logic [DAY_W-1:0] DAY_SATURDAY = 4'd6;
    localparam logic [DAY_W-1:0] DAY_WEEKEND  = 4'd7;
    localparam logic [DAY_W-1:0] DAY_EVERY    = 4'd8;

    typedef struct packed {
        logic [LIGHT_W-1:0]  light;
        logic [MINUTE_W-1:0] minute;
        logic [DAY_W-1:0]    day;
        logic                on;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic wr_en;
    } t_chain_ctl;

    function automatic logic day_match(input logic [DAY_W-1:0] today,
                                       input logic [DAY_W-1:0] sel);
        logic m;
        if (sel == DAY_EVERY) begin
            m = 1'b1;
        end else if (sel == DAY_WEEKEND) begin
            m = (today == DAY_SATURDAY) || (today == DAY_SUNDAY);
        end else begin
            m = (today == sel);
        end
        return m;
    endfunction

endpackage

@@ design/lesu_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesu_in_if / lesu_out_if
// Valid/ready channels for scheduler requests and light commands.
// ----------------------------------------------------------------------------
interface lesu_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [lesu_pkg::LIGHT_W-1:0]  lamp_id;
    logic [lesu_pkg::DAY_W-1:0]    day;
    logic [lesu_pkg::MINUTE_W-1:0] minute;
    logic                          turn_on;

    modport source (output valid, action, lamp_id, day, minute, turn_on, input ready);
    modport sink   (input valid, action, lamp_id, day, minute, turn_on, output ready);
endinterface

interface lesu_out_if;
    logic                         valid;
    logic                         ready;
    logic [lesu_pkg::LIGHT_W-1:0] out_lamp_id;
    logic                         switch_on;
    logic                         last;

    modport source (output valid, out_lamp_id, switch_on, last, input ready);
    modport sink   (input valid, out_lamp_id, switch_on, last, output ready);
endinterface

@@ design/lesu_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesu_cell
// One event slot: loads a new event or takes its neighbor's event on shift.
// ----------------------------------------------------------------------------
module lesu_cell (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_shift,
    input  lesu_pkg::t_entry i_load_data,
    input  lesu_pkg::t_entry i_next,
    output lesu_pkg::t_entry o_entry
);
    import lesu_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_load) begin
            n_entry = i_load_data;
        end else if (i_shift) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ design/lesu_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesu_chain
// Ring of event cells; a shift rotates every event one slot toward the head.
// ----------------------------------------------------------------------------
module lesu_chain #(
    parameter  int MAX_EVENTS = lesu_pkg::LESU_MAX_EVENTS,
    localparam int CNT_W      = $clog2(MAX_EVENTS + 1)
) (
    input  logic                 i_clk,
    input  lesu_pkg::t_chain_ctl i_ctl,
    input  logic [CNT_W-1:0]     i_wr_idx,
    input  lesu_pkg::t_entry     i_wr_data,
    output lesu_pkg::t_entry     o_head
);
    import lesu_pkg::*;

    t_entry w_entry [MAX_EVENTS];

    for (genvar g = 0; g < MAX_EVENTS; g++) begin : g_cell
        lesu_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (i_ctl.wr_en && (i_wr_idx == CNT_W'(g))),
            .i_shift     (i_ctl.shift),
            .i_load_data (i_wr_data),
            .i_next      (w_entry[(g + 1) % MAX_EVENTS]),
            .o_entry     (w_entry[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

@@ design/light_event_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_event_scheduler_unit
// Table of scheduled light events, scanned on each tick request.
// ----------------------------------------------------------------------------
//   i_in carries one request per transaction. action = schedule appends an
//   event (lamp, minute, day selector, on/off); it is dropped when the table
//   already holds MAX_EVENTS events. action = tick carries today's weekday
//   and minute; o_out then delivers, in scheduling order, one command per
//   due event, with last set on the final one, or nothing if none is due.
//   Flow: schedules are accepted one per cycle while idle. After a tick
//   i_in.ready stays low while the ring rotates one slot per cycle, when not
//   stalled, past the compare at its head cell; the scan state then ends and
//   the flush state releases the final command, if any, before a new request
//   is taken. A stall on o_out holds the ring when a due event finds both the
//   pending slot and the output register full, and holds the final release.
//   Reset empties the table and drops any command in flight; the event
//   storage itself is not cleared.
// ----------------------------------------------------------------------------
`include "light_event_scheduler_unit_macros.svh"

module light_event_scheduler_unit #(
    parameter int MAX_EVENTS = lesu_pkg::LESU_MAX_EVENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lesu_in_if.sink           i_in,
    lesu_out_if.source        o_out
);
    import lesu_pkg::*;

    localparam int CNT_W = $clog2(MAX_EVENTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state              r_state,      n_state;
    logic [CNT_W-1:0]    r_count,      n_count;
    logic [CNT_W-1:0]    r_step,       n_step;
    logic [DAY_W-1:0]    r_day,        n_day;
    logic [MINUTE_W-1:0] r_minute,     n_minute;
    logic                r_pend_valid, n_pend_valid;
    logic [LIGHT_W-1:0]  r_pend_light, n_pend_light;
    logic                r_pend_on,    n_pend_on;
    logic                r_out_valid,  n_out_valid;
    logic [LIGHT_W-1:0]  r_out_light,  n_out_light;
    logic                r_out_on,     n_out_on;
    logic                r_out_last,   n_out_last;

    t_chain_ctl w_ctl;
    t_entry     w_wr_data;
    t_entry     w_head;
    logic       w_accept;
    logic       w_hit;
    logic       w_out_free;
    logic       w_push;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_hit = (r_step < r_count) && (w_head.minute == r_minute)
                   && day_match(r_day, w_head.day);

    assign w_wr_data.light  = i_in.lamp_id;
    assign w_wr_data.minute = i_in.minute;
    assign w_wr_data.day    = i_in.day;
    assign w_wr_data.on     = i_in.turn_on;

    lesu_chain #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_wr_idx  (r_count),
        .i_wr_data (w_wr_data),
        .o_head    (w_head)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_day        = r_day;
        n_minute     = r_minute;
        n_pend_valid = r_pend_valid;
        n_pend_light = r_pend_light;
        n_pend_on    = r_pend_on;
        n_out_light  = r_out_light;
        n_out_on     = r_out_on;
        n_out_last   = r_out_last;
        w_ctl        = '0;
        w_push       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in.action == ACT_SCHEDULE) begin
                        if (r_count < CNT_W'(MAX_EVENTS)) begin
                            w_ctl.wr_en = 1'b1;
                            n_count     = r_count + 1'b1;
                        end
                    end else begin
                        n_day    = i_in.day;
                        n_minute = i_in.minute;
                        n_step   = '0;
                        n_state  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_step == CNT_W'(MAX_EVENTS)) begin
                    n_state = ST_FLUSH;
                end else if (!(w_hit && r_pend_valid) || w_out_free) begin
                    w_ctl.shift = 1'b1;
                    n_step      = r_step + 1'b1;
                    if (w_hit) begin
                        if (r_pend_valid) begin
                            w_push      = 1'b1;
                            n_out_light = r_pend_light;
                            n_out_on    = r_pend_on;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_light = w_head.light;
                        n_pend_on    = w_head.on;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    w_push       = 1'b1;
                    n_out_light  = r_pend_light;
                    n_out_on     = r_pend_on;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_out_valid = w_push || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_step       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_step       <= n_step;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_day        <= n_day;
        r_minute     <= n_minute;
        r_pend_light <= n_pend_light;
        r_pend_on    <= n_pend_on;
        r_out_light  <= n_out_light;
        r_out_on     <= n_out_on;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_lamp_id = r_out_light;
    assign o_out.switch_on   = r_out_on;
    assign o_out.last        = r_out_last;

    `LESU_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_EVENTS))
    `LESU_ASSERT_NOW(a_push_free, i_clk, i_rst_n, w_push, w_out_free)
    `LESU_ASSERT_NOW(a_idle_no_pend, i_clk, i_rst_n, r_state == ST_IDLE, !r_pend_valid)
    `LESU_ASSERT_NEXT(a_scan_end, i_clk, i_rst_n,
        (r_state == ST_SCAN) && (r_step == CNT_W'(MAX_EVENTS)), r_state == ST_FLUSH)

endmodule

@@ bench/lesu_command_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesu_command_checker
// Watches the request and command channels of the light event scheduler.
// Keeps its own copy of the event table and works out, for each accepted
// tick, the commands that are due. Each accepted command is compared field
// by field with the oldest one still due.
// ----------------------------------------------------------------------------
module lesu_command_checker
    import lesu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    lesu_in_if   i_req,
    lesu_out_if  i_cmd,
    output int   o_fail_count,
    output int   o_cmds_pending,
    output int   o_cmds_checked
);

    typedef struct packed {
        logic [LIGHT_W-1:0] light;
        logic               on;
        logic               last;
    } t_light_cmd;

    t_entry     sched_table [LESU_MAX_EVENTS];
    int         sched_fill = 0;
    t_light_cmd due_cmds [$];
    int         fail_count = 0;
    int         cmds_checked = 0;
    int         cmds_pending = 0;

    assign o_fail_count   = fail_count;
    assign o_cmds_pending = cmds_pending;
    assign o_cmds_checked = cmds_checked;

    function automatic logic selector_hits(input logic [DAY_W-1:0] today,
                                           input logic [DAY_W-1:0] sel);
        case (sel)
            DAY_EVERY:   return 1'b1;
            DAY_WEEKEND: return (today == DAY_SUNDAY) || (today == DAY_SATURDAY);
            default:     return today == sel;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_light_cmd got;
        t_light_cmd want;
        t_light_cmd fresh;
        logic       any_due;
        if (!i_rst_n) begin
            sched_fill = 0;
            due_cmds.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                if (i_req.action == ACT_SCHEDULE) begin
                    if (sched_fill < LESU_MAX_EVENTS) begin
                        sched_table[sched_fill] = '{light:  i_req.lamp_id,
                                                    minute: i_req.minute,
                                                    day:    i_req.day,
                                                    on:     i_req.turn_on};
                        sched_fill++;
                    end
                end else begin
                    any_due = 1'b0;
                    for (int k = 0; k < sched_fill; k++) begin
                        if (sched_table[k].minute == i_req.minute &&
                            selector_hits(i_req.day, sched_table[k].day)) begin
                            fresh    = '{light: sched_table[k].light,
                                         on:    sched_table[k].on,
                                         last:  1'b0};
                            due_cmds = {due_cmds, fresh};
                            any_due  = 1'b1;
                        end
                    end
                    // mark the final command of this tick
                    if (any_due) begin
                        due_cmds[due_cmds.size() - 1].last = 1'b1;
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                got = '{light: i_cmd.out_lamp_id, on: i_cmd.switch_on, last: i_cmd.last};
                if (due_cmds.size() == 0) begin
                    $error("light command for lamp %0d with no command due", got.light);
                    fail_count++;
                end else begin
                    want = due_cmds.pop_front();
                    cmds_checked++;
                    if (got.light !== want.light) begin
                        $error("out_lamp_id: expected %0d, actual %0d", want.light, got.light);
                        fail_count++;
                    end
                    if (got.on !== want.on) begin
                        $error("switch_on: expected %0b, actual %0b", want.on, got.on);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, got.last);
                        fail_count++;
                    end
                end
            end
        end
        cmds_pending = due_cmds.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the light event scheduler. Schedules events with
// extreme and special day selectors, then ticks that hit each of them, then
// a random mix of schedules and ticks that fills the table, overflows it and
// keeps ticking at popular minutes. Both channels idle and stall at random,
// apart from one stretch with full throughput.
// ----------------------------------------------------------------------------
module tb_top;
    import lesu_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic calm    = 1'b0;
    int   fail_count;
    int   cmds_pending;
    int   cmds_checked;
    int   n_sched = 0;
    int   n_tick  = 0;

    lesu_in_if  in_ch ();
    lesu_out_if out_ch ();

    light_event_scheduler_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lesu_command_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (in_ch),
        .i_cmd          (out_ch),
        .o_fail_count   (fail_count),
        .o_cmds_pending (cmds_pending),
        .o_cmds_checked (cmds_checked)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(99) >= 10);
    end

    task automatic send_request(input logic                act,
                                input logic [LIGHT_W-1:0]  light,
                                input logic [DAY_W-1:0]    day,
                                input logic [MINUTE_W-1:0] minute,
                                input logic                on);
        if (!calm && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.action  <= act;
        in_ch.lamp_id <= light;
        in_ch.day     <= day;
        in_ch.minute  <= minute;
        in_ch.turn_on <= on;
        do @(posedge i_clk); while (!in_ch.ready);
        if (act == ACT_TICK) begin
            n_tick++;
        end else begin
            n_sched++;
        end
    endtask

    initial begin
        logic [MINUTE_W-1:0] hot_minutes [4];
        logic                act;
        logic [DAY_W-1:0]    d;
        logic [MINUTE_W-1:0] m;
        int                  counted;
        int                  roll;
        int                  drain_cycles;

        hot_minutes = '{11'd720, 11'd0, 11'd2047, 11'd1439};
        in_ch.valid   <= 1'b0;
        in_ch.action  <= ACT_SCHEDULE;
        in_ch.lamp_id <= '0;
        in_ch.day     <= '0;
        in_ch.minute  <= '0;
        in_ch.turn_on <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // events with extreme fields and every kind of day selector
        send_request(ACT_SCHEDULE, 8'hFF, DAY_EVERY, 11'd2047, 1'b1);
        send_request(ACT_SCHEDULE, 8'h00, 4'hF, 11'd0, 1'b0);
        send_request(ACT_SCHEDULE, 8'hA5, DAY_WEEKEND, 11'd720, 1'b1);
        send_request(ACT_SCHEDULE, 8'h5A, 4'd3, 11'd720, 1'b0);
        send_request(ACT_SCHEDULE, 8'h3C, 4'd9, 11'd720, 1'b1);
        send_request(ACT_SCHEDULE, 8'hC3, DAY_EVERY, 11'd720, 1'b0);

        // ticks that hit weekend, weekday, odd selectors and nothing at all
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), DAY_SUNDAY, 11'd720,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), DAY_SATURDAY, 11'd720,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), 4'd3, 11'd720,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), 4'd9, 11'd720,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), DAY_WEEKEND, 11'd720,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), DAY_EVERY, 11'd720,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), 4'hF, 11'd0,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), 4'd2, 11'd2047,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), 4'd1, 11'd1,
                     1'($urandom_range(1)));
        send_request(ACT_TICK, LIGHT_W'($urandom_range(255)), 4'd4, 11'd1439,
                     1'($urandom_range(1)));

        counted = 0;
        while (counted < 300) begin
            calm <= (counted >= 140) && (counted < 200);
            if (n_sched < LESU_MAX_EVENTS) begin
                act = ($urandom_range(1) == 0) ? ACT_SCHEDULE : ACT_TICK;
            end else begin
                act = ($urandom_range(99) < 10) ? ACT_SCHEDULE : ACT_TICK;
            end
            roll = $urandom_range(99);
            if (act == ACT_SCHEDULE) begin
                if (roll < 30) begin
                    d = DAY_EVERY;
                end else if (roll < 45) begin
                    d = DAY_WEEKEND;
                end else if (roll < 90) begin
                    d = DAY_W'($urandom_range(6));
                end else begin
                    d = DAY_W'($urandom_range(15, 7));
                end
                m = ($urandom_range(99) < 75) ? hot_minutes[2'($urandom_range(3))]
                                              : MINUTE_W'($urandom_range(2047));
                // a schedule into a full table is dropped and does not count
                if (n_sched < LESU_MAX_EVENTS) begin
                    counted++;
                end
            end else begin
                d = (roll < 85) ? DAY_W'($urandom_range(6)) : DAY_W'($urandom_range(15));
                m = ($urandom_range(99) < 80) ? hot_minutes[2'($urandom_range(3))]
                                              : MINUTE_W'($urandom_range(2047));
                counted++;
            end
            send_request(act, LIGHT_W'($urandom_range(255)), d, m, 1'($urandom_range(1)));
        end

        in_ch.valid <= 1'b0;
        calm        <= 1'b0;
        drain_cycles = 0;
        while (cmds_pending != 0 && drain_cycles < 100000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (2 * LESU_MAX_EVENTS + 8) @(posedge i_clk);
        if (cmds_pending != 0) begin
            $error("%0d light commands never arrived", cmds_pending);
        end

        $display("Run covered %0d schedule requests (%0d dropped on a full table) and %0d ticks.",
                 n_sched, (n_sched > LESU_MAX_EVENTS) ? n_sched - LESU_MAX_EVENTS : 0, n_tick);
        $display("%0d light commands were compared against the predicted table scan.",
                 cmds_checked);
        if (fail_count == 0 && cmds_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
